@@ hdl/jddm_pkg.sv @@
// Shared constants, codes and stage payload types for the joystick drive mixer.
`default_nettype none
package jddm_pkg;

   // Stick sample width; the center and full scale follow from it.
   localparam int STICK_BITS = 11;
   localparam int SPEED_BITS = 7;
   localparam int MODE_BITS = 4;
   localparam int DEADBAND_BITS = 11;
   localparam int COMPARE_BITS = 13;

   localparam int STICK_CENTRE = 2 ** (STICK_BITS - 1);
   localparam int STICK_FULL = 2 ** STICK_BITS - 1;

   // Compare value is distance * speed / SPEED_DIVISOR, saturated.
   localparam int SPEED_DIVISOR = 25;
   localparam logic [COMPARE_BITS-1:0] COMPARE_MAX = {COMPARE_BITS{1'b1}};

   localparam logic [DEADBAND_BITS-1:0] DEADBAND_LOW_RESET = DEADBAND_BITS'(819);
   localparam logic [DEADBAND_BITS-1:0] DEADBAND_HIGH_RESET = DEADBAND_BITS'(1228);

   // Product of a distance and the speed factor.
   localparam int PROD_BITS = STICK_BITS + SPEED_BITS;

   // Register map.
   localparam int CSR_INDEX_BITS = 1;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEADBAND_LOW  = 1'b0,
      CSR_DEADBAND_HIGH = 1'b1
   } csr_index_type;

   // Spin mode codes, only meaningful inside the center deadband.
   localparam logic [MODE_BITS-1:0] MODE_SPIN_LEFT = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_STOP = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_SPIN_RIGHT = 4'd3;

   typedef struct packed {
      logic [STICK_BITS-1:0] dist_left;
      logic [STICK_BITS-1:0] dist_right;
      logic [SPEED_BITS-1:0] speed;
      logic                  left_reverse;
      logic                  right_reverse;
      logic                  hit;
   } dist_type;

   typedef struct packed {
      logic [PROD_BITS-1:0] prod_left;
      logic [PROD_BITS-1:0] prod_right;
      logic                 left_reverse;
      logic                 right_reverse;
      logic                 hit;
   } prod_type;

endpackage
`default_nettype wire

@@ hdl/jddm_req_if.sv @@
// Request channel: one joystick sample word with valid/ready.
`default_nettype none
interface jddm_req_if;
   logic                                valid;
   logic                                ready;
   logic [jddm_pkg::STICK_BITS-1:0]     stick_x;
   logic [jddm_pkg::STICK_BITS-1:0]     stick_y;
   logic [jddm_pkg::SPEED_BITS-1:0]     speed;
   logic [jddm_pkg::MODE_BITS-1:0]      spin_mode;

   modport source (output valid, stick_x, stick_y, speed, spin_mode, input ready);
   modport sink (input valid, stick_x, stick_y, speed, spin_mode, output ready);
endinterface
`default_nettype wire

@@ hdl/jddm_rsp_if.sv @@
// Response channel: one motor command word with valid/ready.
`default_nettype none
interface jddm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [jddm_pkg::COMPARE_BITS-1:0]   left_compare;
   logic [jddm_pkg::COMPARE_BITS-1:0]   right_compare;
   logic                                left_reverse;
   logic                                right_reverse;
   logic                                rule_matched;

   modport source (output valid, left_compare, right_compare, left_reverse,
                   right_reverse, rule_matched, input ready);
   modport sink (input valid, left_compare, right_compare, left_reverse,
                 right_reverse, rule_matched, output ready);
endinterface
`default_nettype wire

@@ hdl/jddm_decode.sv @@
// Input register and region decode into registered per-motor distances.
`default_nettype none
module jddm_decode (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   jddm_req_if.sink                                  req,
   input  wire logic [jddm_pkg::DEADBAND_BITS-1:0]   deadband_low,
   input  wire logic [jddm_pkg::DEADBAND_BITS-1:0]   deadband_high,
   output logic                                      dist_valid,
   input  wire logic                                 dist_ready,
   output jddm_pkg::dist_type                        dist_word
);
   import jddm_pkg::*;

   // Signed compare width covering stick and deadband values.
   localparam int CW = ((STICK_BITS > DEADBAND_BITS) ? STICK_BITS : DEADBAND_BITS) + 2;

   logic                  in_valid_ff;
   logic [STICK_BITS-1:0] x_ff;
   logic [STICK_BITS-1:0] y_ff;
   logic [SPEED_BITS-1:0] speed_ff;
   logic [MODE_BITS-1:0]  mode_ff;
   logic                  in_ready;

   logic                  dist_valid_ff;
   dist_type              dist_ff;
   dist_type              dist_in;

   logic signed [CW-1:0]  xs, ys, lo, hi, cen, full, m, n;
   logic signed [CW-1:0]  dl, dr;
   logic                  in_box, mid_x;

   function automatic logic [STICK_BITS-1:0] clamp_dist(input logic signed [CW-1:0] d);
      if (d <= 0) begin
         clamp_dist = '0;
      end else begin
         clamp_dist = d[STICK_BITS-1:0];
      end
   endfunction

   assign in_ready  = !dist_valid_ff || dist_ready;
   assign req.ready = !in_valid_ff || in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         x_ff     <= req.stick_x;
         y_ff     <= req.stick_y;
         speed_ff <= req.speed;
         mode_ff  <= req.spin_mode;
      end
   end

   assign xs   = signed'(CW'(x_ff));
   assign ys   = signed'(CW'(y_ff));
   assign lo   = signed'(CW'(deadband_low));
   assign hi   = signed'(CW'(deadband_high));
   assign cen  = signed'(CW'(STICK_CENTRE));
   assign full = signed'(CW'(STICK_FULL));
   assign m    = full - xs;
   assign n    = full - ys;

   assign in_box = (xs < hi) && (ys < hi) && (xs > lo) && (ys > lo);
   assign mid_x  = (xs <= hi) && (xs >= lo);

   // Rules in priority order; no match leaves hit low.
   always_comb begin
      dl = '0;
      dr = '0;
      dist_in.left_reverse  = 1'b0;
      dist_in.right_reverse = 1'b0;
      dist_in.hit           = 1'b1;
      if (in_box && mode_ff == MODE_STOP) begin
         dl = '0;
      end else if (in_box && mode_ff == MODE_SPIN_LEFT) begin
         dl = cen;
         dr = cen;
         dist_in.left_reverse = 1'b1;
      end else if (in_box && mode_ff == MODE_SPIN_RIGHT) begin
         dl = cen;
         dr = cen;
         dist_in.right_reverse = 1'b1;
      end else if (mid_x && ys >= hi) begin
         dl = ys - cen;
         dr = ys - cen;
      end else if (mid_x && ys <= lo) begin
         dl = cen - ys;
         dr = cen - ys;
         dist_in.left_reverse  = 1'b1;
         dist_in.right_reverse = 1'b1;
      end else if (xs > hi && ys > hi) begin
         if (ys >= xs) begin
            dl = ys - cen;
            dr = ys - xs;
         end else begin
            dl = xs - cen;
            dr = xs - ys;
            dist_in.right_reverse = 1'b1;
         end
      end else if (xs < lo && ys > hi) begin
         if (ys > m) begin
            dl = ys - m;
            dr = ys - cen;
         end else begin
            dl = m - ys;
            dr = m;
            dist_in.left_reverse = 1'b1;
         end
      end else if (xs < lo && ys < lo) begin
         if (n > m) begin
            dl = n - cen;
            dr = n - m;
         end
         dist_in.left_reverse  = 1'b1;
         dist_in.right_reverse = 1'b1;
      end else if (xs > hi && ys < lo) begin
         if (n > xs) begin
            dl = n - xs;
            dr = n - cen;
         end
         dist_in.left_reverse  = 1'b1;
         dist_in.right_reverse = 1'b1;
      end else begin
         dist_in.hit = 1'b0;
      end
      dist_in.dist_left  = clamp_dist(dl);
      dist_in.dist_right = clamp_dist(dr);
      dist_in.speed      = speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_valid_ff <= 1'b0;
      end else if (in_ready) begin
         dist_valid_ff <= in_valid_ff;
      end
      if (in_valid_ff && in_ready) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_valid = dist_valid_ff;
   assign dist_word  = dist_ff;

endmodule
`default_nettype wire

@@ hdl/jddm_mult.sv @@
// Distance times speed for both motors, registered.
`default_nettype none
module jddm_mult (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                dist_valid,
   output logic                     dist_ready,
   input  wire jddm_pkg::dist_type  dist_word,
   output logic                     prod_valid,
   input  wire logic                prod_ready,
   output jddm_pkg::prod_type       prod
);
   import jddm_pkg::*;

   logic     prod_valid_ff;
   prod_type prod_ff;
   prod_type prod_in;

   assign dist_ready = !prod_valid_ff || prod_ready;

   always_comb begin
      prod_in.prod_left     = PROD_BITS'(dist_word.dist_left) * PROD_BITS'(dist_word.speed);
      prod_in.prod_right    = PROD_BITS'(dist_word.dist_right) * PROD_BITS'(dist_word.speed);
      prod_in.left_reverse  = dist_word.left_reverse;
      prod_in.right_reverse = dist_word.right_reverse;
      prod_in.hit           = dist_word.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (dist_ready) begin
         prod_valid_ff <= dist_valid;
      end
      if (dist_valid && dist_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule
`default_nettype wire

@@ hdl/jddm_out.sv @@
// Divide by the speed divisor, saturate, hold on no match, output register.
`default_nettype none
module jddm_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                prod_valid,
   output logic                     prod_ready,
   input  wire jddm_pkg::prod_type  prod,
   jddm_rsp_if.source               rsp
);
   import jddm_pkg::*;

   // Reciprocal multiply, exact for every product below 2**PROD_BITS.
   localparam int RECIP_SHIFT = PROD_BITS + 5;
   localparam int RECIP = (2 ** RECIP_SHIFT + SPEED_DIVISOR - 1) / SPEED_DIVISOR;
   localparam int RECIP_BITS = RECIP_SHIFT - 4;
   localparam int FULL_BITS = PROD_BITS + RECIP_BITS;
   localparam int QUOT_BITS = FULL_BITS - RECIP_SHIFT;
   localparam int EXT_BITS = (QUOT_BITS > COMPARE_BITS) ? QUOT_BITS : COMPARE_BITS;

   logic                    out_valid_ff;
   logic [COMPARE_BITS-1:0] left_cmp_ff, right_cmp_ff;
   logic                    left_rev_ff, right_rev_ff, matched_ff;

   logic [COMPARE_BITS-1:0] held_left_cmp_ff, held_right_cmp_ff;
   logic                    held_left_rev_ff, held_right_rev_ff;

   logic [COMPARE_BITS-1:0] left_sat, right_sat;
   logic [COMPARE_BITS-1:0] left_cmp_in, right_cmp_in;
   logic                    left_rev_in, right_rev_in;
   logic                    take;

   function automatic logic [COMPARE_BITS-1:0] div_sat(input logic [PROD_BITS-1:0] p);
      logic [FULL_BITS-1:0] full;
      logic [QUOT_BITS-1:0] q;
      logic [EXT_BITS-1:0]  q_ext;
      full  = FULL_BITS'(p) * FULL_BITS'(RECIP);
      q     = full[FULL_BITS-1:RECIP_SHIFT];
      q_ext = EXT_BITS'(q);
      if (q_ext > EXT_BITS'(COMPARE_MAX)) begin
         div_sat = COMPARE_MAX;
      end else begin
         div_sat = q_ext[COMPARE_BITS-1:0];
      end
   endfunction

   assign prod_ready = !out_valid_ff || rsp.ready;
   assign take       = prod_valid && prod_ready;

   assign left_sat  = div_sat(prod.prod_left);
   assign right_sat = div_sat(prod.prod_right);

   always_comb begin
      if (prod.hit) begin
         left_cmp_in  = left_sat;
         right_cmp_in = right_sat;
         left_rev_in  = prod.left_reverse;
         right_rev_in = prod.right_reverse;
      end else begin
         left_cmp_in  = held_left_cmp_ff;
         right_cmp_in = held_right_cmp_ff;
         left_rev_in  = held_left_rev_ff;
         right_rev_in = held_right_rev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff      <= 1'b0;
         held_left_cmp_ff  <= COMPARE_BITS'(1);
         held_right_cmp_ff <= COMPARE_BITS'(1);
         held_left_rev_ff  <= 1'b0;
         held_right_rev_ff <= 1'b0;
      end else begin
         if (prod_ready) begin
            out_valid_ff <= prod_valid;
         end
         if (take) begin
            held_left_cmp_ff  <= left_cmp_in;
            held_right_cmp_ff <= right_cmp_in;
            held_left_rev_ff  <= left_rev_in;
            held_right_rev_ff <= right_rev_in;
         end
      end
      if (take) begin
         left_cmp_ff  <= left_cmp_in;
         right_cmp_ff <= right_cmp_in;
         left_rev_ff  <= left_rev_in;
         right_rev_ff <= right_rev_in;
         matched_ff   <= prod.hit;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.left_compare  = left_cmp_ff;
   assign rsp.right_compare = right_cmp_ff;
   assign rsp.left_reverse  = left_rev_ff;
   assign rsp.right_reverse = right_rev_ff;
   assign rsp.rule_matched  = matched_ff;

endmodule
`default_nettype wire

@@ hdl/joystick_differential_drive_mixer.sv @@
// Top level of the joystick differential-drive mixer.
`default_nettype none
// Maps one joystick word (X, Y centered at mid-scale, speed, spin mode) to
// left/right PWM compare values and reverse bits. Compare = distance * speed
// / 25, truncated and saturated at 8191; values are raw and can exceed the
// 1023 PWM period. Inside the center deadband the spin mode selects stop,
// spin left or spin right; outside it, forward, backward and four diagonal
// quadrants apply. When no rule matches, the last command is repeated and
// rule_matched is 0. Four registers in a row: input register, region decode
// into the distance register, multiply into the product register, reciprocal
// divide into the output register. A new word is accepted every cycle while
// rsp_ch is ready. Each stage loads whenever it is empty or its word moves
// on, so a stalled rsp_ch backs the pipe up one stage at a time and
// req_ch.ready drops once all four registers hold words. Deadband edges are
// written through the csr_ port; the user must write them only while no word
// is in flight, and the block itself does not enforce it.
module joystick_differential_drive_mixer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   jddm_req_if.sink                                   req_ch,
   jddm_rsp_if.source                                 rsp_ch,
   input  wire logic                                  csr_write_enable,
   input  wire logic [jddm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [jddm_pkg::DEADBAND_BITS-1:0]    csr_write_data
);
   import jddm_pkg::*;

   // Deadband edges, applied to both axes.
   logic [DEADBAND_BITS-1:0] deadband_low_ff;
   logic [DEADBAND_BITS-1:0] deadband_high_ff;

   // Stage links.
   logic     dist_valid, dist_ready;
   dist_type dist_word;
   logic     prod_valid, prod_ready;
   prod_type prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_low_ff  <= DEADBAND_LOW_RESET;
         deadband_high_ff <= DEADBAND_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DEADBAND_LOW:  deadband_low_ff  <= csr_write_data;
            CSR_DEADBAND_HIGH: deadband_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register + region decode -> distances.
   jddm_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .deadband_low  (deadband_low_ff),
      .deadband_high (deadband_high_ff),
      .dist_valid    (dist_valid),
      .dist_ready    (dist_ready),
      .dist_word     (dist_word)
   );

   // Distance * speed.
   jddm_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .dist_valid (dist_valid),
      .dist_ready (dist_ready),
      .dist_word  (dist_word),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   // Divide by 25, saturate, hold, response register.
   jddm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp        (rsp_ch)
   );

   // Deadband edges come out of reset at their defaults.
   a_deadband_reset: assert property (@(posedge clock)
      reset |=> (deadband_low_ff == DEADBAND_LOW_RESET) &&
                (deadband_high_ff == DEADBAND_HIGH_RESET))
      else $error("deadband registers not at reset value");

   // Left-only reverse is spin left or upper-left turn: right never slower.
   a_left_turn_order: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.rule_matched && rsp_ch.left_reverse &&
      !rsp_ch.right_reverse |-> rsp_ch.right_compare >= rsp_ch.left_compare)
      else $error("left reverse with right compare below left");

   // A stalled distance word must not be overwritten between stages.
   a_dist_hold: assert property (@(posedge clock) disable iff (reset)
      dist_valid && !dist_ready |=> dist_valid && $stable(dist_word))
      else $error("distance stage lost a word under stall");

endmodule
`default_nettype wire
